@@ design/modbus_rtu_frame_checker_top_macros.svh @@
// Assertion helpers shared by the frame checker.
`ifndef MODBUS_RTU_FRAME_CHECKER_TOP_MACROS_SVH
`define MODBUS_RTU_FRAME_CHECKER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MRFC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame checker assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MRFC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame checker assertion failed");

`endif

@@ design/mrfc_pkg.sv @@
`default_nettype none

package mrfc_pkg;

    // Longest frame that can be accepted; longer frames are flagged.
    localparam int MAX_FRAME = 256;
    // Byte counter saturates at MAX_FRAME + 1.
    localparam int CNT_W = $clog2(MAX_FRAME + 2);
    localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_FRAME + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME);
    localparam logic [CNT_W-1:0] CNT_MIN_OK = CNT_W'(4);

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [7:0] BCAST_ADDR = 8'hFF;

    localparam logic [7:0] SLAVE_ADDR_RESET = 8'd1;
    localparam logic [15:0] GAP_TICKS_RESET = 16'd750;

    // Configuration register indexes.
    localparam logic REG_SLAVE_ADDR = 1'b0;
    localparam logic REG_GAP_TICKS = 1'b1;

    // Input item kinds.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef enum logic [2:0] {
        STAT_OK         = 3'd0,
        STAT_TOO_SHORT  = 3'd1,
        STAT_OTHER_ADDR = 3'd2,
        STAT_CRC_ERR    = 3'd3,
        STAT_TOO_LONG   = 3'd4
    } status_t;

    typedef struct packed {
        status_t          status;
        logic             broadcast;
        logic [7:0]       address;
        logic [CNT_W-1:0] length;
    } frame_result_t;

endpackage

`default_nettype wire

@@ design/mrfc_crc16.sv @@
`default_nettype none

module mrfc_crc16 (
    input  wire logic [15:0] crc_in,
    input  wire logic [7:0]  data,
    output logic [15:0]      crc_out
);
    import mrfc_pkg::*;

    // Reflected CRC-16, one byte: eight shift and conditional xor steps.
    always_comb
    begin
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule

`default_nettype wire

@@ design/mrfc_frame.sv @@
`default_nettype none

module mrfc_frame (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   item_fire,
    input  wire logic                   item_kind,
    input  wire logic [7:0]             item_byte,
    input  wire logic [7:0]             slave_address,
    input  wire logic [15:0]            gap_ticks,
    output logic                        res_valid,
    output mrfc_pkg::frame_result_t     res
);
    import mrfc_pkg::*;

    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       hold0_reg, hold0_next;
    logic [7:0]       hold1_reg, hold1_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       first_reg, first_next;
    logic [15:0]      idle_reg, idle_next;
    logic [15:0]      crc_upd;
    logic [15:0]      trailer;
    logic             frame_open;
    logic             gap_done;

    mrfc_crc16 u_crc (
        .crc_in  (crc_reg),
        .data    (hold0_reg),
        .crc_out (crc_upd)
    );

    assign frame_open = (count_reg != '0);
    assign gap_done   = (idle_reg >= gap_ticks);
    assign trailer    = {hold1_reg, hold0_reg};
    assign res_valid  = item_fire && (item_kind == KIND_TICK) && frame_open && gap_done;

    // Frame status, checked in priority order.
    always_comb
    begin
        if (count_reg < CNT_MIN_OK)
        begin
            res.status = STAT_TOO_SHORT;
        end
        else if (count_reg > CNT_MAX)
        begin
            res.status = STAT_TOO_LONG;
        end
        else if ((first_reg != BCAST_ADDR) && (first_reg != slave_address))
        begin
            res.status = STAT_OTHER_ADDR;
        end
        else if (trailer != crc_reg)
        begin
            res.status = STAT_CRC_ERR;
        end
        else
        begin
            res.status = STAT_OK;
        end
        res.broadcast = (first_reg == BCAST_ADDR);
        res.address   = first_reg;
        res.length    = count_reg;
    end

    // Frame state update for one transfer.
    always_comb
    begin
        crc_next   = crc_reg;
        hold0_next = hold0_reg;
        hold1_next = hold1_reg;
        count_next = count_reg;
        first_next = first_reg;
        idle_next  = idle_reg;
        if (item_fire)
        begin
            if (item_kind == KIND_BYTE)
            begin
                // The older held byte leaves the trailer window into the CRC.
                if (count_reg[CNT_W-1:1] != '0)
                begin
                    crc_next = crc_upd;
                end
                if (!frame_open)
                begin
                    first_next = item_byte;
                end
                hold0_next = hold1_reg;
                hold1_next = item_byte;
                if (count_reg != CNT_SAT)
                begin
                    count_next = count_reg + 1'b1;
                end
                idle_next = '0;
            end
            else if (frame_open)
            begin
                if (gap_done)
                begin
                    crc_next   = CRC_INIT;
                    hold0_next = '0;
                    hold1_next = '0;
                    count_next = '0;
                    first_next = '0;
                    idle_next  = '0;
                end
                else
                begin
                    idle_next = idle_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= CRC_INIT;
            hold0_reg <= '0;
            hold1_reg <= '0;
            count_reg <= '0;
            first_reg <= '0;
            idle_reg  <= '0;
        end
        else
        begin
            crc_reg   <= crc_next;
            hold0_reg <= hold0_next;
            hold1_reg <= hold1_next;
            count_reg <= count_next;
            first_reg <= first_next;
            idle_reg  <= idle_next;
        end
    end

endmodule

`default_nettype wire

@@ design/modbus_rtu_frame_checker_top.sv @@
// A transfer is registered in the input register and processed from there once the
// result register can take a result; the result of the tick that ends a frame is
// registered in the result register, from which it transfers on the result stream.
// Throughput: one byte or tick per cycle; only a held output result stalls input.
// Reset (rst_n, asynchronous, active low) empties both stages, sets
// slave_address to 1, gap_ticks to 750 and clears the frame state.
`default_nettype none
`include "modbus_rtu_frame_checker_top_macros.svh"

module modbus_rtu_frame_checker_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration write port.
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data,
    // Input stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic        s_tuser,   // [0] kind
    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [2:0] status, [10:3] frame_address,
                                        // [19:11] frame_length, [23:20] zero
    output logic             m_tuser    // [0] broadcast
);
    import mrfc_pkg::*;

    logic [7:0]    slave_address_reg;
    logic [15:0]   gap_ticks_reg;
    logic          in_valid_reg, in_valid_next;
    logic          in_kind_reg;
    logic [7:0]    in_byte_reg;
    logic          out_valid_reg, out_valid_next;
    frame_result_t out_res_reg;
    logic          proc_fire;
    logic          res_valid;
    frame_result_t res;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_address_reg <= SLAVE_ADDR_RESET;
            gap_ticks_reg     <= GAP_TICKS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SLAVE_ADDR: slave_address_reg <= cfg_data[7:0];
                REG_GAP_TICKS:  gap_ticks_reg     <= cfg_data;
                default:        slave_address_reg <= slave_address_reg;
            endcase
        end
    end

    // The registered item is processed once the result slot can take a result.
    assign proc_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proc_fire;

    // Input register.
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tready)
        begin
            in_valid_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_kind_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    mrfc_frame u_frame (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_fire     (proc_fire),
        .item_kind     (in_kind_reg),
        .item_byte     (in_byte_reg),
        .slave_address (slave_address_reg),
        .gap_ticks     (gap_ticks_reg),
        .res_valid     (res_valid),
        .res           (res)
    );

    // Result register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_res_reg.length, out_res_reg.address,
                       out_res_reg.status};
    assign m_tuser  = out_res_reg.broadcast;

    // Checks on the result stage.
    `MRFC_ASSERT_NXT(a_result_loaded, proc_fire && res_valid, out_valid_reg)
    `MRFC_ASSERT_IMP(a_status_legal, m_tvalid, m_tdata[2:0] <= STAT_TOO_LONG)
    `MRFC_ASSERT_IMP(a_ok_length, m_tvalid && (m_tdata[2:0] == STAT_OK),
        (m_tdata[19:11] >= CNT_MIN_OK) && (m_tdata[19:11] <= CNT_MAX))
    `MRFC_ASSERT_IMP(a_bcast_addr, m_tvalid && m_tuser,
        (m_tdata[10:3] == BCAST_ADDR) && (m_tdata[2:0] != STAT_OTHER_ADDR))

endmodule

`default_nettype wire
